// ===== rtl/core/bgi_pkg.sv =====
// Shared types and constants for the bilinear grid interpolator.
package bgi_pkg;

  localparam int MAX_R_POINTS  = 64;
  localparam int MAX_Z_POINTS  = 64;
  localparam int PLANE_COUNT   = 4;
  localparam int FRACTION_BITS = 16;

  localparam int VALUE_W = 32;
  localparam int R_IDX_W = $clog2(MAX_R_POINTS);
  localparam int Z_IDX_W = $clog2(MAX_Z_POINTS);
  localparam int PLANE_W = $clog2(PLANE_COUNT);
  localparam int PTS_W   = 7;
  localparam int FRAC_W  = FRACTION_BITS + 1;
  localparam int POS_W   = 2 * VALUE_W - FRACTION_BITS;
  localparam int PROD_W  = VALUE_W + FRAC_W + 1;
  localparam int SUM_W   = PROD_W + 1;

  localparam int BANK_AW    = PLANE_W + (R_IDX_W - 1) + (Z_IDX_W - 1);
  localparam int BANK_DEPTH = 1 << BANK_AW;

  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [FRAC_W-1:0]  ONE_FIX   = FRAC_W'(1) << FRACTION_BITS;
  localparam logic [VALUE_W-1:0] ONE_VALUE = VALUE_W'(1) << FRACTION_BITS;
  localparam logic [PTS_W-1:0]   R_PTS_MAX = PTS_W'(MAX_R_POINTS);
  localparam logic [PTS_W-1:0]   Z_PTS_MAX = PTS_W'(MAX_Z_POINTS);
  localparam logic [PTS_W-1:0]   PTS_MIN   = PTS_W'(2);

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_R_LOW    = 3'd0,
    CFG_R_HIGH   = 3'd1,
    CFG_R_INV    = 3'd2,
    CFG_Z_LOW    = 3'd3,
    CFG_Z_HIGH   = 3'd4,
    CFG_Z_INV    = 3'd5,
    CFG_R_POINTS = 3'd6,
    CFG_Z_POINTS = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    kind_t                      kind;
    logic [PLANE_W-1:0]         plane_select;
    logic [R_IDX_W-1:0]         write_r_index;
    logic [Z_IDX_W-1:0]         write_z_index;
    logic signed [VALUE_W-1:0]  write_value;
    logic signed [VALUE_W-1:0]  query_r;
    logic signed [VALUE_W-1:0]  query_z;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  interp_value;
    logic                       degenerate;
  } out_item_t;

endpackage

// ===== rtl/core/bilinear_grid_interpolator.sv =====
// Bilinear interpolator over field planes on a uniform R-Z grid, banked sample memory.
//
// Input channel (in_valid/in_ready/in_data) carries write beats and query beats.
// A write beat stores one sample and marks its plane loaded; it returns nothing.
// A query beat returns one out_data beat: the blended value, or zero with
// degenerate set when the plane is unloaded or either axis has under two points.
// Samples sit in four memories banked by the parity of the R and Z indices, so
// the four corners of a cell are read in the same cycle; writes and reads both hit
// the memories at the same pipeline stage, which keeps them in beat order.
// Throughput: one beat per cycle while in_ready is high. A query passes through
// clamp, multiply, cell select, memory read, two multiply/add pairs and the
// output queue.
// A 16-entry output queue holds finished results; in_ready stays high while
// fewer than 16 queries are in flight or queued, so a stalled receiver backs
// the input up only after 16 outstanding queries.
// Reset (rst_n low at a clock edge) clears the loaded flags, the pipeline and
// the queue, and returns the configuration registers to their defaults.
// Configuration writes (cfg_write_en/cfg_index/cfg_data) take effect at once.
module bilinear_grid_interpolator
  import bgi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration
  logic signed [VALUE_W-1:0] r_low_r, r_high_r, z_low_r, z_high_r;
  logic [VALUE_W-1:0]        r_inv_r, z_inv_r;
  logic [PTS_W-1:0]          r_pts_r, z_pts_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_low_r  <= '0;
      r_high_r <= ONE_VALUE;
      r_inv_r  <= ONE_VALUE;
      z_low_r  <= '0;
      z_high_r <= ONE_VALUE;
      z_inv_r  <= ONE_VALUE;
      r_pts_r  <= '0;
      z_pts_r  <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_R_LOW:    r_low_r  <= cfg_data[VALUE_W-1:0];
        CFG_R_HIGH:   r_high_r <= cfg_data[VALUE_W-1:0];
        CFG_R_INV:    r_inv_r  <= cfg_data[VALUE_W-1:0];
        CFG_Z_LOW:    z_low_r  <= cfg_data[VALUE_W-1:0];
        CFG_Z_HIGH:   z_high_r <= cfg_data[VALUE_W-1:0];
        CFG_Z_INV:    z_inv_r  <= cfg_data[VALUE_W-1:0];
        CFG_R_POINTS: r_pts_r  <= cfg_data[PTS_W-1:0];
        CFG_Z_POINTS: z_pts_r  <= cfg_data[PTS_W-1:0];
        default: ;
      endcase
    end
  end

  logic [PTS_W-1:0] r_pts_sat, z_pts_sat, r_lim, z_lim;
  logic             grid_small;

  assign r_pts_sat  = (r_pts_r > R_PTS_MAX) ? R_PTS_MAX : r_pts_r;
  assign z_pts_sat  = (z_pts_r > Z_PTS_MAX) ? Z_PTS_MAX : z_pts_r;
  assign grid_small = (r_pts_sat < PTS_MIN) || (z_pts_sat < PTS_MIN);
  assign r_lim      = (r_pts_sat < PTS_MIN) ? '0 : r_pts_sat - PTS_MIN;
  assign z_lim      = (z_pts_sat < PTS_MIN) ? '0 : z_pts_sat - PTS_MIN;

  // handshake and credit count
  logic             in_fire, out_fire, in_query;
  logic [CNT_W-1:0] pending_r, pending_nxt;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign in_query = in_data.kind == KIND_QUERY;
  assign in_ready = pending_r < CNT_W'(FIFO_DEPTH);

  always_comb begin
    pending_nxt = pending_r;
    if (in_fire && in_query && !out_fire) begin
      pending_nxt = pending_r + CNT_W'(1);
    end else if (!(in_fire && in_query) && out_fire) begin
      pending_nxt = pending_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  // stage 1: clamp to span and take the offset from the first grid point
  function automatic logic [VALUE_W-1:0] grid_offset(
    input logic signed [VALUE_W-1:0] q,
    input logic signed [VALUE_W-1:0] lo,
    input logic signed [VALUE_W-1:0] hi
  );
    logic signed [VALUE_W-1:0] c;
    logic signed [VALUE_W:0]   diff;
    c    = (q < lo) ? lo : q;
    c    = (c > hi) ? hi : c;
    diff = {c[VALUE_W-1], c} - {lo[VALUE_W-1], lo};
    return diff[VALUE_W] ? '0 : diff[VALUE_W-1:0];
  endfunction

  logic                      s1_valid_r;
  kind_t                     s1_kind_r;
  logic [PLANE_W-1:0]        s1_plane_r;
  logic [R_IDX_W-1:0]        s1_wr_r;
  logic [Z_IDX_W-1:0]        s1_wz_r;
  logic signed [VALUE_W-1:0] s1_wval_r;
  logic [VALUE_W-1:0]        s1_dr_r, s1_dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    s1_kind_r  <= in_data.kind;
    s1_plane_r <= in_data.plane_select;
    s1_wr_r    <= in_data.write_r_index;
    s1_wz_r    <= in_data.write_z_index;
    s1_wval_r  <= in_data.write_value;
    s1_dr_r    <= grid_offset(in_data.query_r, r_low_r, r_high_r);
    s1_dz_r    <= grid_offset(in_data.query_z, z_low_r, z_high_r);
  end

  // stage 2: scale by reciprocal spacing
  logic [2*VALUE_W-1:0]      s2_prod_r, s2_prod_z;
  logic                      s2_valid_r;
  kind_t                     s2_kind_r;
  logic [PLANE_W-1:0]        s2_plane_r;
  logic [R_IDX_W-1:0]        s2_wr_r;
  logic [Z_IDX_W-1:0]        s2_wz_r;
  logic signed [VALUE_W-1:0] s2_wval_r;
  logic [POS_W-1:0]          s2_pr_r, s2_pz_r;

  assign s2_prod_r = s1_dr_r * r_inv_r;
  assign s2_prod_z = s1_dz_r * z_inv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_kind_r  <= s1_kind_r;
    s2_plane_r <= s1_plane_r;
    s2_wr_r    <= s1_wr_r;
    s2_wz_r    <= s1_wz_r;
    s2_wval_r  <= s1_wval_r;
    s2_pr_r    <= s2_prod_r[2*VALUE_W-1:FRACTION_BITS];
    s2_pz_r    <= s2_prod_z[2*VALUE_W-1:FRACTION_BITS];
  end

  // stage 3: cell index and fraction; past the last cell the fraction is 1.0
  logic                        r_clamp, z_clamp;
  logic [R_IDX_W-1:0]          r_cell;
  logic [Z_IDX_W-1:0]          z_cell;
  logic [FRAC_W-1:0]           r_frac, z_frac;

  assign r_clamp = s2_pr_r[POS_W-1:FRACTION_BITS] > (POS_W - FRACTION_BITS)'(r_lim);
  assign z_clamp = s2_pz_r[POS_W-1:FRACTION_BITS] > (POS_W - FRACTION_BITS)'(z_lim);
  assign r_cell  = r_clamp ? r_lim[R_IDX_W-1:0]
                           : s2_pr_r[FRACTION_BITS +: R_IDX_W];
  assign z_cell  = z_clamp ? z_lim[Z_IDX_W-1:0]
                           : s2_pz_r[FRACTION_BITS +: Z_IDX_W];
  assign r_frac  = r_clamp ? ONE_FIX : {1'b0, s2_pr_r[FRACTION_BITS-1:0]};
  assign z_frac  = z_clamp ? ONE_FIX : {1'b0, s2_pz_r[FRACTION_BITS-1:0]};

  logic                      s3_valid_r;
  kind_t                     s3_kind_r;
  logic [PLANE_W-1:0]        s3_plane_r;
  logic [R_IDX_W-1:0]        s3_cr_r;
  logic [Z_IDX_W-1:0]        s3_cz_r;
  logic [FRAC_W-1:0]         s3_s_r, s3_t_r;
  logic signed [VALUE_W-1:0] s3_wval_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_kind_r  <= s2_kind_r;
    s3_plane_r <= s2_plane_r;
    s3_cr_r    <= (s2_kind_r == KIND_WRITE) ? s2_wr_r : r_cell;
    s3_cz_r    <= (s2_kind_r == KIND_WRITE) ? s2_wz_r : z_cell;
    s3_s_r     <= r_frac;
    s3_t_r     <= z_frac;
    s3_wval_r  <= s2_wval_r;
  end

  // memory stage: writes and corner reads meet here, so order is kept
  logic                     s3_write, s3_query;
  logic [PLANE_COUNT-1:0]   loaded_r;
  logic [VALUE_W-1:0]       rd_data [2][2];

  assign s3_write = s3_valid_r && (s3_kind_r == KIND_WRITE);
  assign s3_query = s3_valid_r && (s3_kind_r == KIND_QUERY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= '0;
    end else if (s3_write) begin
      loaded_r[s3_plane_r] <= 1'b1;
    end
  end

  for (genvar gz = 0; gz < 2; gz++) begin : g_zbank
    for (genvar gr = 0; gr < 2; gr++) begin : g_rbank
      logic [VALUE_W-1:0] bank_mem [BANK_DEPTH];
      logic [VALUE_W-1:0] bank_rd_r;
      logic [Z_IDX_W-1:0] zsel;
      logic [R_IDX_W-1:0] rsel;
      logic [BANK_AW-1:0] addr;
      logic               we;

      // the corner row/column of this parity: the cell's own or the next one
      assign zsel = (s3_cz_r[0] == 1'(gz)) ? s3_cz_r : s3_cz_r + Z_IDX_W'(1);
      assign rsel = (s3_cr_r[0] == 1'(gr)) ? s3_cr_r : s3_cr_r + R_IDX_W'(1);
      assign addr = {s3_plane_r, zsel[Z_IDX_W-1:1], rsel[R_IDX_W-1:1]};
      assign we   = s3_write && (s3_cz_r[0] == 1'(gz)) && (s3_cr_r[0] == 1'(gr));

      always_ff @(posedge clk) begin
        if (we) begin
          bank_mem[addr] <= s3_wval_r;
        end
        bank_rd_r <= bank_mem[addr];
      end

      assign rd_data[gz][gr] = bank_rd_r;
    end
  end

  logic              s4_valid_r, s4_deg_r, s4_iz0_r, s4_ir0_r;
  logic [FRAC_W-1:0] s4_s_r, s4_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else begin
      s4_valid_r <= s3_query;
    end
  end

  always_ff @(posedge clk) begin
    s4_deg_r <= !loaded_r[s3_plane_r] || grid_small;
    s4_iz0_r <= s3_cz_r[0];
    s4_ir0_r <= s3_cr_r[0];
    s4_s_r   <= s3_s_r;
    s4_t_r   <= s3_t_r;
  end

  // stage 4: route banks to corners, weight along R
  logic [VALUE_W-1:0] col_lo [2];
  logic [VALUE_W-1:0] col_hi [2];
  logic [VALUE_W-1:0] v00, v01, v10, v11;
  logic [FRAC_W-1:0]  s_inv;

  assign col_lo[0] = s4_ir0_r ? rd_data[0][1] : rd_data[0][0];
  assign col_hi[0] = s4_ir0_r ? rd_data[0][0] : rd_data[0][1];
  assign col_lo[1] = s4_ir0_r ? rd_data[1][1] : rd_data[1][0];
  assign col_hi[1] = s4_ir0_r ? rd_data[1][0] : rd_data[1][1];
  assign v00   = s4_iz0_r ? col_lo[1] : col_lo[0];
  assign v01   = s4_iz0_r ? col_hi[1] : col_hi[0];
  assign v10   = s4_iz0_r ? col_lo[0] : col_lo[1];
  assign v11   = s4_iz0_r ? col_hi[0] : col_hi[1];
  assign s_inv = ONE_FIX - s4_s_r;

  logic                     s5_valid_r, s5_deg_r;
  logic [FRAC_W-1:0]        s5_t_r;
  logic signed [PROD_W-1:0] s5_m00_r, s5_m01_r, s5_m10_r, s5_m11_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
    end else begin
      s5_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s5_deg_r <= s4_deg_r;
    s5_t_r   <= s4_t_r;
    s5_m00_r <= $signed(v00) * $signed({1'b0, s_inv});
    s5_m01_r <= $signed(v01) * $signed({1'b0, s4_s_r});
    s5_m10_r <= $signed(v10) * $signed({1'b0, s_inv});
    s5_m11_r <= $signed(v11) * $signed({1'b0, s4_s_r});
  end

  // stage 5: row sums, floor shift (convex blend always fits the value width)
  logic signed [SUM_W-1:0] row0_sum, row1_sum;

  assign row0_sum = SUM_W'(s5_m00_r) + SUM_W'(s5_m01_r);
  assign row1_sum = SUM_W'(s5_m10_r) + SUM_W'(s5_m11_r);

  logic                      s6_valid_r, s6_deg_r;
  logic [FRAC_W-1:0]         s6_t_r;
  logic signed [VALUE_W-1:0] s6_a0_r, s6_a1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_valid_r <= 1'b0;
    end else begin
      s6_valid_r <= s5_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s6_deg_r <= s5_deg_r;
    s6_t_r   <= s5_t_r;
    s6_a0_r  <= row0_sum[FRACTION_BITS +: VALUE_W];
    s6_a1_r  <= row1_sum[FRACTION_BITS +: VALUE_W];
  end

  // stage 6: weight along Z
  logic [FRAC_W-1:0]        t_inv;
  logic                     s7_valid_r, s7_deg_r;
  logic signed [PROD_W-1:0] s7_m0_r, s7_m1_r;

  assign t_inv = ONE_FIX - s6_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_valid_r <= 1'b0;
    end else begin
      s7_valid_r <= s6_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s7_deg_r <= s6_deg_r;
    s7_m0_r  <= s6_a0_r * $signed({1'b0, t_inv});
    s7_m1_r  <= s6_a1_r * $signed({1'b0, s6_t_r});
  end

  // stage 7: final sum into the output queue
  logic signed [SUM_W-1:0] res_sum;
  out_item_t               push_item;

  assign res_sum                = SUM_W'(s7_m0_r) + SUM_W'(s7_m1_r);
  assign push_item.degenerate   = s7_deg_r;
  assign push_item.interp_value = s7_deg_r ? '0 : res_sum[FRACTION_BITS +: VALUE_W];

  // output queue
  out_item_t          fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   fifo_cnt_r;

  always_ff @(posedge clk) begin
    if (s7_valid_r) begin
      fifo_mem[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (s7_valid_r) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (out_fire) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      if (s7_valid_r && !out_fire) begin
        fifo_cnt_r <= fifo_cnt_r + CNT_W'(1);
      end else if (!s7_valid_r && out_fire) begin
        fifo_cnt_r <= fifo_cnt_r - CNT_W'(1);
      end
    end
  end

  assign out_valid = fifo_cnt_r != '0;
  assign out_data  = fifo_mem[rd_ptr_r];

  // checks
  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= CNT_W'(FIFO_DEPTH))
    else $error("outstanding query count above queue depth");

  a_queue_within_credit: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt_r <= pending_r)
    else $error("queue holds more beats than outstanding queries");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    s7_valid_r |-> (fifo_cnt_r < CNT_W'(FIFO_DEPTH)) || out_fire)
    else $error("push into a full output queue");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.degenerate) |-> (out_data.interp_value == '0))
    else $error("degenerate beat with nonzero value");

  a_write_marks_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    s3_write |=> loaded_r[$past(s3_plane_r)])
    else $error("plane not marked loaded after a write");

endmodule

// ===== sim/bgi_scoreboard_pkg.sv =====
`timescale 1ns / 100ps
// Scoreboard class with a bit-exact predictor of the bilinear grid interpolator.
package bgi_scoreboard_pkg;
  import bgi_pkg::*;

  localparam int     GRID_WORDS = PLANE_COUNT * MAX_Z_POINTS * MAX_R_POINTS;
  localparam longint UNIT       = longint'(1) << FRACTION_BITS;

  class interp_scoreboard;
    logic [VALUE_W-1:0]    samples [GRID_WORDS];
    bit                    stored  [GRID_WORDS];
    bit                    loaded  [PLANE_COUNT];
    logic [CFG_DATA_W-1:0] regs    [8];
    out_item_t             answers_due [$];
    int                    errors;

    function new();
      regs[CFG_R_LOW]    = '0;
      regs[CFG_R_HIGH]   = ONE_VALUE;
      regs[CFG_R_INV]    = ONE_VALUE;
      regs[CFG_Z_LOW]    = '0;
      regs[CFG_Z_HIGH]   = ONE_VALUE;
      regs[CFG_Z_INV]    = ONE_VALUE;
      regs[CFG_R_POINTS] = '0;
      regs[CFG_Z_POINTS] = '0;
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_R_POINTS || idx == CFG_Z_POINTS) begin
        regs[idx] = CFG_DATA_W'(val[PTS_W-1:0]);
      end else begin
        regs[idx] = val;
      end
    endfunction

    // point counts above the array size saturate
    function int points_of(cfg_reg_t idx, int limit);
      int n;
      n = int'(regs[idx][PTS_W-1:0]);
      return (n > limit) ? limit : n;
    endfunction

    function int slot(int plane, int z, int r);
      return (plane * MAX_Z_POINTS + z) * MAX_R_POINTS + r;
    endfunction

    function bit is_stored(int plane, int z, int r);
      return stored[slot(plane, z, r)];
    endfunction

    function int pending();
      return answers_due.size();
    endfunction

    // true when a query will actually read four corners
    function bit reads_grid(in_item_t it);
      return it.kind == KIND_QUERY && int'(it.plane_select) < PLANE_COUNT &&
             loaded[it.plane_select] &&
             points_of(CFG_R_POINTS, MAX_R_POINTS) >= 2 &&
             points_of(CFG_Z_POINTS, MAX_Z_POINTS) >= 2;
    endfunction

    function void locate(input longint q, lo, hi, input logic [31:0] inv, input int pts,
                         output int cell_idx, output longint frac);
      longint      c, d;
      logic [63:0] du, pos, idx, rem;
      c = (q < lo) ? lo : q;
      if (c > hi) c = hi;
      d = c - lo;
      if (d < 0) d = 0;   // inverted span
      du  = d;
      pos = (du * {32'd0, inv}) >> FRACTION_BITS;
      idx = pos >> FRACTION_BITS;
      if (idx > 64'(pts - 2)) idx = 64'(pts - 2);
      rem = pos - (idx << FRACTION_BITS);
      if (rem > 64'(UNIT)) rem = 64'(UNIT);
      cell_idx = int'(idx);
      frac     = longint'(rem);
    endfunction

    function void find_cell(input in_item_t it, output int ir, output longint s,
                            output int iz, output longint t);
      locate($signed(it.query_r), $signed(regs[CFG_R_LOW]), $signed(regs[CFG_R_HIGH]),
             regs[CFG_R_INV], points_of(CFG_R_POINTS, MAX_R_POINTS), ir, s);
      locate($signed(it.query_z), $signed(regs[CFG_Z_LOW]), $signed(regs[CFG_Z_HIGH]),
             regs[CFG_Z_INV], points_of(CFG_Z_POINTS, MAX_Z_POINTS), iz, t);
    endfunction

    function longint fetch(int plane, int z, int r);
      return longint'($signed(samples[slot(plane, z, r)]));
    endfunction

    function out_item_t interpolate(in_item_t it);
      out_item_t o;
      int        ir, iz, p;
      longint    s, t, v00, v01, v10, v11, a0, a1;
      o.interp_value = '0;
      o.degenerate   = 1'b1;
      if (!reads_grid(it)) return o;
      p = int'(it.plane_select);
      find_cell(it, ir, s, iz, t);
      v00 = fetch(p, iz, ir);
      v01 = fetch(p, iz, ir + 1);
      v10 = fetch(p, iz + 1, ir);
      v11 = fetch(p, iz + 1, ir + 1);
      // arithmetic shift of a signed sum is a floor divide
      a0 = (v00 * (UNIT - s) + v01 * s) >>> FRACTION_BITS;
      a1 = (v10 * (UNIT - s) + v11 * s) >>> FRACTION_BITS;
      o.interp_value = VALUE_W'((a0 * (UNIT - t) + a1 * t) >>> FRACTION_BITS);
      o.degenerate   = 1'b0;
      return o;
    endfunction

    function void note_input(in_item_t it);
      int a;
      if (it.kind == KIND_WRITE) begin
        if (int'(it.plane_select) < PLANE_COUNT) begin
          a = slot(it.plane_select, it.write_z_index, it.write_r_index);
          samples[a] = it.write_value;
          stored[a]  = 1'b1;
          loaded[it.plane_select] = 1'b1;
        end
      end else begin
        answers_due = {answers_due, interpolate(it)};
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (answers_due.size() == 0) begin
        $display("%0t: result beat with nothing pending: expected none, actual %h/%b",
                 $time, got.interp_value, got.degenerate);
        errors++;
        return;
      end
      want = answers_due.pop_front();
      if (got.interp_value !== want.interp_value) begin
        $display("%0t: interp_value mismatch: expected %h, actual %h",
                 $time, want.interp_value, got.interp_value);
        errors++;
      end
      if (got.degenerate !== want.degenerate) begin
        $display("%0t: degenerate mismatch: expected %b, actual %b",
                 $time, want.degenerate, got.degenerate);
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== sim/tb_bilinear_grid_interpolator.sv =====
`timescale 1ns / 100ps
// Top-level bench: drives write and query beats, grid settings, and checks each result.
module tb_bilinear_grid_interpolator;
  import bgi_pkg::*;
  import bgi_scoreboard_pkg::*;

  localparam int SETTLE_CYCLES = 12;
  localparam int PHASES        = 10;
  localparam int PHASE_BEATS   = 135;

  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  in_valid     = 1'b0;
  logic                  in_ready;
  in_item_t              in_data      = '0;
  logic                  out_valid;
  logic                  out_ready    = 1'b0;
  out_item_t             out_data;
  logic                  cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;
  bit                    steady       = 1'b0;  // suppresses random idling on both sides
  int                    sent         = 0;     // input beats accepted so far

  interp_scoreboard sb;

  bilinear_grid_interpolator dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 11);
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  initial begin
    #600_000;
    $display("tb_bilinear_grid_interpolator NOT OK");
    $finish;
  end

  // called at a clock edge; returns at the edge where the beat is taken
  task automatic send_item(in_item_t it);
    if (!steady && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic load_grid(logic [31:0] rl, rh, ri, zl, zh, zi, logic [6:0] rp, zp);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_R_LOW, rl);
    write_reg(CFG_R_HIGH, rh);
    write_reg(CFG_R_INV, ri);
    write_reg(CFG_Z_LOW, zl);
    write_reg(CFG_Z_HIGH, zh);
    write_reg(CFG_Z_INV, zi);
    write_reg(CFG_R_POINTS, 32'(rp));
    write_reg(CFG_Z_POINTS, 32'(zp));
    cfg_write_en <= 1'b0;
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($urandom_range(0, 32'h0002_0000)) - 32'h0001_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t make_write(int plane, int r, int z, logic [31:0] value);
    in_item_t it;
    it.kind          = KIND_WRITE;
    it.plane_select  = PLANE_W'(plane);
    it.write_r_index = R_IDX_W'(r);
    it.write_z_index = Z_IDX_W'(z);
    it.write_value   = value;
    it.query_r       = $urandom;
    it.query_z       = $urandom;
    return it;
  endfunction

  // mostly inside the span, with edges, wrap extremes and noise
  function automatic logic [31:0] pick_coord(logic [31:0] lo, logic [31:0] hi);
    longint l, h, span;
    l    = $signed(lo);
    h    = $signed(hi);
    span = h - l;
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom;
      3: return 32'(l + longint'($urandom_range(0, 6)) - 3);
      4: return 32'(h + longint'($urandom_range(0, 6)) - 3);
      default: begin
        if (span <= 0) return 32'(l + longint'($urandom_range(0, 64)) - 32);
        return 32'(l + longint'({$urandom, $urandom} % (span + 1)));
      end
    endcase
  endfunction

  // any corner this query reads that was never written is written first
  task automatic send_query(int plane, logic [31:0] qr, logic [31:0] qz);
    in_item_t it;
    int       ir, iz;
    longint   s, t;
    it.kind          = KIND_QUERY;
    it.plane_select  = PLANE_W'(plane);
    it.write_r_index = R_IDX_W'($urandom);
    it.write_z_index = Z_IDX_W'($urandom);
    it.write_value   = $urandom;
    it.query_r       = qr;
    it.query_z       = qz;
    if (sb.reads_grid(it)) begin
      sb.find_cell(it, ir, s, iz, t);
      for (int dz = 0; dz < 2; dz++) begin
        for (int dr = 0; dr < 2; dr++) begin
          if (!sb.is_stored(int'(it.plane_select), iz + dz, ir + dr))
            send_item(make_write(int'(it.plane_select), ir + dr, iz + dz, rand_sample()));
        end
      end
    end
    send_item(it);
  endtask

  function automatic void uniform_axis(input int pts, output logic [31:0] lo, hi, inv);
    longint l, h;
    h   = longint'($urandom_range(32'h0000_1000, 32'h0004_0000));
    l   = longint'($urandom_range(0, 32'h0100_0000)) - 64'sh0080_0000;
    lo  = 32'(l);
    hi  = 32'(l + longint'(pts - 1) * h);
    inv = 32'((longint'(1) << 32) / h);
  endfunction

  initial begin
    logic [31:0] rl, rh, ri, zl, zh, zi;
    logic [6:0]  rp, zp;
    int          phase_end;
    bit          held;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset grid: no points in use, nothing loaded
    load_grid('0, ONE_VALUE, ONE_VALUE, '0, ONE_VALUE, ONE_VALUE, '0, '0);
    send_query(0, '0, '0);
    send_item(make_write(0, 0, 0, 32'h7FFF_FFFF));
    send_query(0, 32'h8000, 32'h8000);

    // smallest grid, corners at the value extremes
    load_grid('0, ONE_VALUE, ONE_VALUE, '0, ONE_VALUE, ONE_VALUE, 7'd2, 7'd2);
    send_item(make_write(0, 1, 0, 32'h8000_0000));
    send_item(make_write(0, 0, 1, 32'h8000_0000));
    send_item(make_write(0, 1, 1, 32'h7FFF_FFFF));
    send_query(0, '0, '0);
    send_query(0, ONE_VALUE, ONE_VALUE);
    send_query(0, 32'h8000, 32'h8000);
    send_query(0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_query(0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_query(0, 32'h4000, 32'hC000);
    send_query(2, 32'h8000, 32'h8000);

    // saturating point counts, inverted R span, full Z span with largest reciprocal
    load_grid(ONE_VALUE, 32'hFFFF_0000, 32'hFFFF_FFFF,
              32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 7'd127, 7'd100);
    send_query(0, $urandom, 32'h8000_0000);
    send_query(0, '0, '0);
    send_query(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_query(0, 32'h8000_0000, 32'h8000_0001);

    for (int ph = 0; ph < PHASES; ph++) begin
      rp = 7'(2 + $urandom_range(0, 62));
      zp = 7'(2 + $urandom_range(0, 62));
      case (ph)
        1: begin rp = 7'd64; zp = 7'd64; end
        2: begin rp = 7'd2;  zp = 7'd2;  end
        3: begin rp = 7'($urandom_range(65, 127)); zp = 7'($urandom_range(65, 127)); end
        5: rp = 7'($urandom_range(0, 1));
        9: begin rp = 7'($urandom_range(2, 4)); zp = 7'($urandom_range(0, 1)); end
        default: ;
      endcase
      uniform_axis((rp > 7'd64) ? 64 : ((rp < 7'd2) ? 2 : int'(rp)), rl, rh, ri);
      uniform_axis((zp > 7'd64) ? 64 : ((zp < 7'd2) ? 2 : int'(zp)), zl, zh, zi);
      case (ph)
        4: begin
          rl = 32'h8000_0000; rh = 32'h7FFF_FFFF; ri = $urandom;
          zl = 32'h8000_0000; zh = 32'h7FFF_FFFF; zi = 32'hFFFF_FFFF;
        end
        6: begin
          rl = rh + $urandom_range(1, 32'h0010_0000); ri = $urandom;
          zl = zh + $urandom_range(1, 32'h0010_0000); zi = $urandom;
        end
        7: begin ri = '0; zi = '0; end
        8: begin
          rl = $urandom; rh = $urandom; ri = $urandom;
          zl = $urandom; zh = $urandom; zi = $urandom;
          rp = 7'($urandom); zp = 7'($urandom);
        end
        default: ;
      endcase
      load_grid(rl, rh, ri, zl, zh, zi, rp, zp);
      steady <= (ph == 3);
      phase_end = sent + PHASE_BEATS;
      held      = 1'b0;
      // corner fills count toward the phase budget
      while (sent < phase_end) begin
        // sender holds off until the pipe is empty once mid-phase
        if (ph == 2 && !held && sent >= phase_end - PHASE_BEATS / 2) begin
          drain();
          held = 1'b1;
        end
        if ($urandom_range(99) < 40) begin
          send_item(make_write($urandom, $urandom, $urandom, rand_sample()));
        end else begin
          send_query($urandom, pick_coord(sb.regs[CFG_R_LOW], sb.regs[CFG_R_HIGH]),
                     pick_coord(sb.regs[CFG_Z_LOW], sb.regs[CFG_Z_HIGH]));
        end
      end
    end

    drain();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_bilinear_grid_interpolator OK");
    end else begin
      $display("tb_bilinear_grid_interpolator NOT OK");
    end
    $finish;
  end

endmodule

// ===== bilinear_grid_interpolator.f =====
rtl/core/bgi_pkg.sv
rtl/core/bilinear_grid_interpolator.sv
sim/bgi_scoreboard_pkg.sv
sim/tb_bilinear_grid_interpolator.sv
